### design/spam_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add package
// Shared types and command codes for the sparse polynomial merge adder.
// ----------------------------------------------------------------------------
`default_nettype none

package spam_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // One stored term.
  typedef struct packed {
    logic signed [15:0] coef;
    logic        [15:0] power;
  } term_t;

  // One merged term, with room for the sum of two coefficients.
  typedef struct packed {
    logic signed [16:0] coef;
    logic        [15:0] power;
  } res_t;

  // Input item.
  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [15:0] term_coef;
    logic        [15:0] term_power;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [16:0] sum_coef;
    logic        [15:0] sum_power;
    logic               last_term;
    logic               empty_sum;
    logic               overflow_seen;
  } out_item_t;

  // Decision of one merge step.
  typedef struct packed {
    logic take_a;
    logic take_b;
    logic produce;
    res_t res;
  } step_t;

endpackage

`default_nettype wire

### design/spam_term_store.sv
// ----------------------------------------------------------------------------
// Term store
// Single-port-write, registered-read memory holding the terms of one list.
// ----------------------------------------------------------------------------
`default_nettype none

module spam_term_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire spam_pkg::term_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output spam_pkg::term_t      rd_data
);

  spam_pkg::term_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/spam_merge_alu.sv
// ----------------------------------------------------------------------------
// Merge step unit
// Compares the two list heads and forms the term that one merge step yields.
// ----------------------------------------------------------------------------
`default_nettype none

module spam_merge_alu (
  input  wire logic            a_live,
  input  wire logic            b_live,
  input  wire spam_pkg::term_t a_term,
  input  wire spam_pkg::term_t b_term,
  output spam_pkg::step_t      step
);

  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;
  logic signed [16:0] sum;

  assign a_ext = 17'(a_term.coef);
  assign b_ext = 17'(b_term.coef);
  assign sum   = a_ext + b_ext;

  always_comb begin
    step = '0;
    if (a_live && b_live) begin
      if (a_term.power > b_term.power) begin
        step.take_a    = 1'b1;
        step.produce   = 1'b1;
        step.res.coef  = a_ext;
        step.res.power = a_term.power;
      end else if (a_term.power < b_term.power) begin
        step.take_b    = 1'b1;
        step.produce   = 1'b1;
        step.res.coef  = b_ext;
        step.res.power = b_term.power;
      end else begin
        // Equal powers combine; a zero sum leaves no term behind.
        step.take_a    = 1'b1;
        step.take_b    = 1'b1;
        step.produce   = (sum != 17'sd0);
        step.res.coef  = sum;
        step.res.power = a_term.power;
      end
    end else if (a_live) begin
      step.take_a    = 1'b1;
      step.produce   = 1'b1;
      step.res.coef  = a_ext;
      step.res.power = a_term.power;
    end else begin
      step.take_b    = b_live;
      step.produce   = b_live;
      step.res.coef  = b_ext;
      step.res.power = b_term.power;
    end
  end

endmodule

`default_nettype wire

### design/sparse_polynomial_add_merge_core.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add merge core
// Loads two term lists and emits their sum, merged by power, on finish.
// ----------------------------------------------------------------------------
// Usage: items enter on the term channel (term_valid/term_stall). A load
// item (cmd 0 or 1) writes one term into list A or list B; a load into a
// full list drops the term and sets a sticky overflow flag. A finish item
// (cmd 2) starts the merge, and cmd 3 is ignored. The merge walks both
// lists with one shared compare/add unit. Each step first reads the list
// heads from the registered-read stores (ST_FETCH) and then compares and
// adds (ST_MERGE); a finish takes at most 2 * MAX_TERMS steps, and a
// stalled receiver can hold a step. term_stall is high for the whole finish.
// Results leave on the sum channel (sum_valid/sum_stall) from an output
// register. One merged term is held back so that the final result can carry
// last_term; a finish with no surviving terms gives one result with
// empty_sum set. While sum_stall holds a valid result, the output holds and
// a step that must hand on the pending term waits. After a finish both
// lists and the overflow flag are cleared.
// Reset empties both lists, clears the flag and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add_merge_core #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               term_valid,
  output logic                    term_stall,
  input  wire spam_pkg::in_item_t term_item,
  output logic                    sum_valid,
  input  wire logic               sum_stall,
  output spam_pkg::out_item_t     sum_item
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;

  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [CW-1:0] ia;
  logic [CW-1:0] ib;
  logic [CW-1:0] ia_next;
  logic [CW-1:0] ib_next;
  logic          overflow_flag;

  // Merged term held back until the next one (or the end) is known.
  logic           pend_valid;
  spam_pkg::res_t pend;

  logic                accept;
  logic                wr_a;
  logic                wr_b;
  logic                out_free;
  logic                a_live;
  logic                b_live;
  logic                step_go;
  logic                push;
  spam_pkg::out_item_t push_item;
  spam_pkg::term_t     wr_term;
  spam_pkg::term_t     a_head;
  spam_pkg::term_t     b_head;
  spam_pkg::step_t     step;

  assign term_stall = (state != ST_IDLE);
  assign accept     = term_valid && !term_stall;
  assign out_free   = !sum_valid || !sum_stall;

  assign wr_term.coef  = term_item.term_coef;
  assign wr_term.power = term_item.term_power;
  assign wr_a = accept && (term_item.cmd == spam_pkg::CMD_LOAD_A) &&
                (count_a < CW'(MAX_TERMS));
  assign wr_b = accept && (term_item.cmd == spam_pkg::CMD_LOAD_B) &&
                (count_b < CW'(MAX_TERMS));

  spam_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a[AW-1:0]),
    .wr_data (wr_term),
    .rd_addr (ia[AW-1:0]),
    .rd_data (a_head)
  );

  spam_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b[AW-1:0]),
    .wr_data (wr_term),
    .rd_addr (ib[AW-1:0]),
    .rd_data (b_head)
  );

  assign a_live = (ia < count_a);
  assign b_live = (ib < count_b);

  spam_merge_alu u_alu (
    .a_live (a_live),
    .b_live (b_live),
    .a_term (a_head),
    .b_term (b_head),
    .step   (step)
  );

  // A step may retire unless it has to hand the pending term to a busy output.
  assign step_go = (state == ST_MERGE) &&
                   (!step.produce || !pend_valid || out_free);
  assign ia_next = ia + CW'(step.take_a);
  assign ib_next = ib + CW'(step.take_b);

  always_comb begin
    push                    = 1'b0;
    push_item.sum_coef      = pend.coef;
    push_item.sum_power     = pend.power;
    push_item.last_term     = 1'b0;
    push_item.empty_sum     = 1'b0;
    push_item.overflow_seen = overflow_flag;
    if (step_go && step.produce && pend_valid) begin
      push = 1'b1;
    end else if ((state == ST_FLUSH) && out_free) begin
      push                = 1'b1;
      push_item.last_term = 1'b1;
      if (!pend_valid) begin
        push_item.sum_coef  = '0;
        push_item.sum_power = '0;
        push_item.empty_sum = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (push) begin
      sum_valid <= 1'b1;
    end else if (!sum_stall) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum_item <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step.produce) begin
      pend <= step.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      ia            <= '0;
      ib            <= '0;
      overflow_flag <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (term_item.cmd)
              spam_pkg::CMD_LOAD_A: begin
                if (wr_a) begin
                  count_a <= count_a + CW'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              spam_pkg::CMD_LOAD_B: begin
                if (wr_b) begin
                  count_b <= count_b + CW'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              spam_pkg::CMD_FINISH: begin
                ia <= '0;
                ib <= '0;
                if ((count_a != '0) || (count_b != '0)) begin
                  state <= ST_FETCH;
                end else begin
                  state <= ST_FLUSH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (step_go) begin
            ia <= ia_next;
            ib <= ib_next;
            if (step.produce) begin
              pend_valid <= 1'b1;
            end
            if ((ia_next < count_a) || (ib_next < count_b)) begin
              state <= ST_FETCH;
            end else begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid    <= 1'b0;
            count_a       <= '0;
            count_b       <= '0;
            ia            <= '0;
            ib            <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
